/* design/slum_pkg.sv */
// Types, command codes and microcode table for the sorted id list union merge.
package slum_pkg;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_MERGE  = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] id_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] merged_id;
        logic        end_of_list;
        logic        last_of_run;
        logic        dropped_loads;
    } out_item_t;

    // Sequencer steps (microcode addresses)
    typedef enum logic [2:0] {
        S_FETCH,
        S_LOAD,
        S_MRD,
        S_MCMP,
        S_MOUT,
        S_FRD,
        S_FCMP,
        S_FTERM
    } step_t;

    // Branch / action condition
    typedef enum logic [1:0] {
        C_ALWAYS,
        C_MORE,     // stored ids remain
        C_LT,       // stored id remains and is below the current id
        C_EQ        // stored id remains and equals the current id
    } cond_t;

    typedef enum logic [1:0] {
        E_NONE,
        E_STORED,
        E_ID,
        E_TERM
    } emit_t;

    typedef struct packed {
        logic  accept;      // take an input item, dispatch on its command
        logic  load_wr;     // append latched id to the store
        cond_t cond;
        emit_t emit_sel;
        logic  emit_if_hit; // emit only when cond holds
        logic  inc_if_hit;  // advance read position when cond holds
        logic  clear;       // reset list state after terminator
        step_t jump_hit;
        step_t jump_miss;
    } ctrl_t;

    function automatic ctrl_t ucode(input step_t s);
        ctrl_t c;
        begin
            c = '0;
            c.jump_hit  = S_FETCH;
            c.jump_miss = S_FETCH;
            unique case (s)
                S_FETCH:
                begin
                    c.accept = 1'b1;
                end
                S_LOAD:
                begin
                    c.load_wr = 1'b1;
                end
                S_MRD:
                begin
                    c.jump_hit  = S_MCMP;
                    c.jump_miss = S_MCMP;
                end
                S_MCMP:
                begin
                    c.cond        = C_LT;
                    c.emit_sel    = E_STORED;
                    c.emit_if_hit = 1'b1;
                    c.inc_if_hit  = 1'b1;
                    c.jump_hit    = S_MRD;
                    c.jump_miss   = S_MOUT;
                end
                S_MOUT:
                begin
                    c.cond       = C_EQ;
                    c.emit_sel   = E_ID;
                    c.inc_if_hit = 1'b1;
                end
                S_FRD:
                begin
                    c.jump_hit  = S_FCMP;
                    c.jump_miss = S_FCMP;
                end
                S_FCMP:
                begin
                    c.cond        = C_MORE;
                    c.emit_sel    = E_STORED;
                    c.emit_if_hit = 1'b1;
                    c.inc_if_hit  = 1'b1;
                    c.jump_hit    = S_FRD;
                    c.jump_miss   = S_FTERM;
                end
                S_FTERM:
                begin
                    c.emit_sel = E_TERM;
                    c.clear    = 1'b1;
                end
                default:
                begin
                    c.accept = 1'b0;
                end
            endcase
            return c;
        end
    endfunction

endpackage

/* design/slum_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module slum_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/sorted_id_list_union_merge_core.sv */
// Sorted id list union merge: microcoded sequencer over a list store.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  in      | input     | in_valid / in_ready | in_data  (command, id_value)
//  out     | output    | out_valid/out_ready | out_data (merged_id, end_of_list,
//          |           |                     |           last_of_run, dropped_loads)
//
// A load is a fetch step then a load step. A merge or finish is a fetch step, then a RAM read
// step and a compare step for each stored id emitted and again for the miss that ends the scan, then S_MOUT or S_FTERM.
// Reset clears counters, flags and sequencer; the store needs no clearing pass.
// A full output register holds the sequencer on any emitting step until its transfer.
// The next item is taken while the last result still waits in the output register.
module sorted_id_list_union_merge_core
    import slum_pkg::*;
#(
    parameter int LIST_CAPACITY = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int CW = $clog2(LIST_CAPACITY + 1);
    localparam int AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
    localparam logic [CW-1:0] CAP = CW'(LIST_CAPACITY);

    step_t          step_reg, step_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic           ovf_reg, ovf_next;
    logic [31:0]    id_reg, id_next;
    logic           out_valid_reg, out_valid_next;
    out_item_t      out_data_reg, out_data_next;

    ctrl_t          ctrl;
    logic [31:0]    rd_data;
    logic           more, hit, want_emit, out_free, stall, fire, wr_en;

    slum_ram #(
        .WIDTH (32),
        .DEPTH (LIST_CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (id_reg),
        .rd_addr (pos_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign ctrl = ucode(step_reg);
    assign more = pos_reg < count_reg;

    always_comb
    begin
        unique case (ctrl.cond)
            C_ALWAYS: hit = 1'b1;
            C_MORE:   hit = more;
            C_LT:     hit = more && (rd_data < id_reg);
            C_EQ:     hit = more && (rd_data == id_reg);
            default:  hit = 1'b0;
        endcase
    end

    assign want_emit = (ctrl.emit_sel != E_NONE) && (hit || !ctrl.emit_if_hit);
    assign out_free  = !out_valid_reg || out_ready;
    assign stall     = want_emit && !out_free;
    assign fire      = want_emit && out_free;
    assign in_ready  = ctrl.accept;

    // next step
    always_comb
    begin
        step_next = step_reg;
        priority if (stall)
        begin
            step_next = step_reg;
        end
        else if (ctrl.accept)
        begin
            if (in_valid)
            begin
                unique case (in_data.command)
                    CMD_LOAD:   step_next = S_LOAD;
                    CMD_MERGE:  step_next = S_MRD;
                    CMD_FINISH: step_next = S_FRD;
                    default:    step_next = S_FETCH;
                endcase
            end
        end
        else
        begin
            step_next = hit ? ctrl.jump_hit : ctrl.jump_miss;
        end
    end

    // datapath actions
    always_comb
    begin
        count_next     = count_reg;
        pos_next       = pos_reg;
        ovf_next       = ovf_reg;
        id_next        = id_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        wr_en          = 1'b0;

        if (ctrl.accept && in_valid)
        begin
            id_next = in_data.id_value;
        end

        if (ctrl.load_wr)
        begin
            if (count_reg < CAP)
            begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        if (!stall && ctrl.inc_if_hit && hit)
        begin
            pos_next = pos_reg + 1'b1;
        end

        if (fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            unique case (ctrl.emit_sel)
                E_STORED:
                begin
                    out_data_next.merged_id = rd_data;
                end
                E_ID:
                begin
                    out_data_next.merged_id   = id_reg;
                    out_data_next.last_of_run = 1'b1;
                end
                E_TERM:
                begin
                    out_data_next.end_of_list   = 1'b1;
                    out_data_next.last_of_run   = 1'b1;
                    out_data_next.dropped_loads = ovf_reg;
                end
                default:
                begin
                    out_valid_next = 1'b0;
                end
            endcase
        end

        if (fire && ctrl.clear)
        begin
            count_next = '0;
            pos_next   = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_FETCH;
            count_reg     <= '0;
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= count_reg)
        else $error("read position passed stored count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("stored count above capacity");

    a_stored_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && ctrl.emit_sel == E_STORED) |=> (pos_reg == $past(pos_reg) + 1'b1))
        else $error("stored id emitted without advancing read position");

    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && ctrl.emit_sel == E_TERM) |=> (count_reg == '0 && pos_reg == '0 && !ovf_reg))
        else $error("terminator did not clear list state");

    a_term_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.end_of_list) |->
            (out_data_reg.last_of_run && out_data_reg.merged_id == 32'd0))
        else $error("malformed terminator");

endmodule
